@@ hw/rtl/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// efp_pkg
// Types and constants shared by the escaped frame parser modules.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;

    localparam logic [BYTE_W-1:0] START_RESET  = 8'd170;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

    typedef enum logic {
        CFG_START  = 1'b0,
        CFG_ESCAPE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_start;
        logic              is_escape;
    } t_item;

    typedef struct packed {
        logic               frame_done;
        logic [BYTE_W-1:0]  frame_length;
        logic [BYTE_W-1:0]  frame_type;
        logic [BYTE_W-1:0]  frame_options;
        logic [BYTE_W-1:0]  frame_check;
        logic               payload_write;
        logic [INDEX_W-1:0] payload_index;
        logic [BYTE_W-1:0]  payload_byte;
    } t_result;

endpackage

@@ hw/rtl/efp_queue.sv @@
// ----------------------------------------------------------------------------
// efp_queue
// Small synchronous FIFO used between the parser stages and at the output.
// ----------------------------------------------------------------------------
module efp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_MAX);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/efp_front.sv @@
// ----------------------------------------------------------------------------
// efp_front
// Configuration registers and byte classification ahead of the item queue.
// ----------------------------------------------------------------------------
module efp_front
    import efp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_item             o_q_item
);

    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_escape;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RESET;
            r_escape <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START:  r_start  <= i_cfg_data;
                CFG_ESCAPE: r_escape <= i_cfg_data;
                default:    r_start  <= r_start;
            endcase
        end
    end

    assign o_q_push           = i_push && !i_q_full;
    assign o_q_item.rx_byte   = i_rx_byte;
    assign o_q_item.is_start  = (i_rx_byte == r_start);
    assign o_q_item.is_escape = (i_rx_byte == r_escape);

endmodule

@@ hw/rtl/efp_back.sv @@
// ----------------------------------------------------------------------------
// efp_back
// Frame state machine: unescape, capture header, emit payload and completion.
// ----------------------------------------------------------------------------
module efp_back
    import efp_pkg::*;
#(
    parameter int HEADER_BYTES = 5,
    parameter int MAX_PAYLOAD  = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_empty,
    input  t_item   i_item,
    output logic    o_in_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_result o_result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [BYTE_W-1:0] HDR_LEN  = BYTE_W'(HEADER_BYTES);
    localparam logic [BYTE_W-1:0] MAX_PLD  = BYTE_W'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        S_WAIT,
        S_LENGTH,
        S_TYPE,
        S_OPTIONS,
        S_CHECK,
        S_PAYLOAD
    } t_state;

    t_state            r_state, n_state;
    logic              r_esc, n_esc;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_length, n_length;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_options, n_options;
    logic [BYTE_W-1:0] r_check, n_check;
    logic              fire;
    logic [BYTE_W-1:0] want;
    logic [BYTE_W-1:0] cnt_next;
    logic [CNT_W+INDEX_W-1:0] cnt_ext;
    t_result           res;

    assign fire       = !i_in_empty && !i_out_full;
    assign o_in_pop   = fire;
    assign o_out_push = fire;
    assign o_result   = res;
    assign want       = r_length - HDR_LEN;
    assign cnt_next   = BYTE_W'(r_count) + 8'd1;
    assign cnt_ext    = {{INDEX_W{1'b0}}, r_count};

    always_comb begin
        n_state   = r_state;
        n_esc     = r_esc;
        n_count   = r_count;
        n_length  = r_length;
        n_type    = r_type;
        n_options = r_options;
        n_check   = r_check;
        res       = '0;
        if (r_state == S_WAIT) begin
            if (i_item.is_start) begin
                n_state = S_LENGTH;
            end
        end else if (i_item.is_escape && !r_esc) begin
            n_esc = 1'b1;
        end else begin
            n_esc = 1'b0;
            unique case (r_state)
                S_LENGTH: begin
                    n_length = i_item.rx_byte;
                    n_state  = (i_item.rx_byte == '0) ? S_WAIT : S_TYPE;
                end
                S_TYPE: begin
                    n_type  = i_item.rx_byte;
                    n_state = S_OPTIONS;
                end
                S_OPTIONS: begin
                    n_options = i_item.rx_byte;
                    n_state   = S_CHECK;
                end
                S_CHECK: begin
                    n_check = i_item.rx_byte;
                    if (r_length > HDR_LEN) begin
                        n_count = '0;
                        n_state = S_PAYLOAD;
                    end else begin
                        n_state = S_WAIT;
                        res.frame_done = 1'b1;
                    end
                end
                S_PAYLOAD: begin
                    res.payload_write = 1'b1;
                    res.payload_index = cnt_ext[INDEX_W-1:0];
                    res.payload_byte  = i_item.rx_byte;
                    n_count = CNT_W'(cnt_next);
                    if (cnt_next >= want || cnt_next >= MAX_PLD) begin
                        n_state = S_WAIT;
                        res.frame_done = 1'b1;
                    end
                end
                default: n_state = S_WAIT;
            endcase
        end
        if (res.frame_done) begin
            res.frame_length  = r_length;
            res.frame_type    = r_type;
            res.frame_options = r_options;
            res.frame_check   = n_check;
        end else begin
            res.frame_check = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WAIT;
            r_esc     <= 1'b0;
            r_count   <= '0;
            r_length  <= '0;
            r_type    <= '0;
            r_options <= '0;
            r_check   <= '0;
        end else if (fire) begin
            r_state   <= n_state;
            r_esc     <= n_esc;
            r_count   <= n_count;
            r_length  <= n_length;
            r_type    <= n_type;
            r_options <= n_options;
            r_check   <= n_check;
        end
    end

    a_no_escape_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !r_esc)
        else $error("escape pending while waiting for start");

    a_count_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAYLOAD) |-> (BYTE_W'(r_count) < MAX_PLD && cnt_next <= want))
        else $error("payload count past frame end");

    a_write_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.payload_write) |-> (r_state == S_PAYLOAD && !n_esc))
        else $error("payload write outside payload phase");

    a_done_returns_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.frame_done) |=> (r_state == S_WAIT))
        else $error("frame done without return to wait");

endmodule

@@ hw/rtl/escaped_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_parser_top
// Byte-stuffed frame parser: header capture, unescaping, indexed payload out.
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------
// input    | push / full        | i_rx_byte
// result   | empty / pop        | o_frame_* , o_payload_*
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the result side is not stalled;
// each byte gives exactly one result, which reaches the outputs through
// the item queue, then the frame state machine into the result queue.
// Synchronous active-low reset clears both queues and the frame state.
// A stalled result side fills the result queue, then the item queue;
// full follows the item queue alone and rises when that queue is full.
// ----------------------------------------------------------------------------
module escaped_frame_parser_top
    import efp_pkg::*;
#(
    parameter int HEADER_BYTES = 5,
    parameter int MAX_PAYLOAD  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic               o_frame_done,
    output logic [BYTE_W-1:0]  o_frame_length,
    output logic [BYTE_W-1:0]  o_frame_type,
    output logic [BYTE_W-1:0]  o_frame_options,
    output logic [BYTE_W-1:0]  o_frame_check,
    output logic               o_payload_write,
    output logic [INDEX_W-1:0] o_payload_index,
    output logic [BYTE_W-1:0]  o_payload_byte,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [BYTE_W-1:0]  i_cfg_data
);

    localparam int QDEPTH = 4;

    logic    q_full, q_push, q_empty, q_pop;
    t_item   q_in_item, q_out_item;
    logic    res_full, res_push;
    t_result res_in, res_out;

    efp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    efp_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QDEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_item),
        .o_empty (q_empty)
    );

    efp_back #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (q_empty),
        .i_item     (q_out_item),
        .o_in_pop   (q_pop),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_result   (res_in)
    );

    efp_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QDEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign full            = q_full;
    assign o_frame_done    = res_out.frame_done;
    assign o_frame_length  = res_out.frame_length;
    assign o_frame_type    = res_out.frame_type;
    assign o_frame_options = res_out.frame_options;
    assign o_frame_check   = res_out.frame_check;
    assign o_payload_write = res_out.payload_write;
    assign o_payload_index = res_out.payload_index;
    assign o_payload_byte  = res_out.payload_byte;

endmodule
